// ===== rtl/u2s_pkg.sv =====
// Package for the UTF-8 to seven-segment core.
// Holds widths, the result status codes, the decode event type and the font tables.
// No dependencies.
package u2s_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SegW   = 8;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned PendW  = 3;
  localparam int unsigned OnesW  = 4;
  localparam int unsigned EntryW = 9;

  localparam logic [CodeW-1:0] ASCII_FIRST = 32'h0000_0020;
  localparam logic [CodeW-1:0] ASCII_LAST  = 32'h0000_007E;
  localparam logic [CodeW-1:0] CYR_FIRST   = 32'h0000_0410;
  localparam logic [CodeW-1:0] CYR_END     = 32'h0000_0450;

  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef enum logic [1:0] {
    STAT_GLYPH   = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_EOS     = 2'd2,
    STAT_ERROR   = 2'd3
  } status_t;

  // One finished character or a decode error, handed from decoder to font stage.
  typedef struct packed {
    logic             valid;
    logic             err;
    logic [CodeW-1:0] code;
  } u2s_event_t;

  // Bit 8 set marks a table entry that has no glyph.
  localparam logic [EntryW-1:0] NG = 9'h100;

  localparam logic [EntryW-1:0] ASCII_FONT [95] = '{
    9'h000, 9'h0B0, 9'h022, NG,     NG,     9'h049, NG,     9'h002,
    9'h04E, 9'h078, 9'h040, NG,     9'h010, 9'h001, 9'h080, NG,
    9'h07E, 9'h030, 9'h06D, 9'h079, 9'h033, 9'h05B, 9'h05F, 9'h070,
    9'h07F, 9'h07B, 9'h048, 9'h058, 9'h043, 9'h009, 9'h061, 9'h065,
    9'h06F, 9'h077, 9'h07F, 9'h04E, 9'h079, 9'h04F, 9'h047, 9'h05E,
    9'h037, 9'h006, 9'h038, 9'h057, 9'h00E, 9'h06B, 9'h076, 9'h07E,
    9'h067, 9'h06B, 9'h06F, 9'h05B, 9'h046, 9'h03E, 9'h03A, 9'h05C,
    9'h049, 9'h02B, 9'h06D, 9'h04E, NG,     9'h078, NG,     9'h008,
    9'h020, 9'h019, 9'h01F, 9'h00D, 9'h03D, 9'h00C, 9'h007, 9'h04D,
    9'h017, 9'h04C, 9'h058, 9'h058, 9'h006, 9'h055, 9'h015, 9'h01D,
    9'h067, 9'h073, 9'h005, 9'h018, 9'h00F, 9'h01C, 9'h018, 9'h02A,
    9'h009, 9'h03B, 9'h009, 9'h031, 9'h006, 9'h007, 9'h063
  };

  localparam logic [EntryW-1:0] CYR_FONT [64] = '{
    9'h077, 9'h05F, 9'h07F, 9'h046, 9'h06A, 9'h04F, NG,     9'h079,
    9'h03E, NG,     9'h057, NG,     9'h06B, 9'h037, 9'h07E, 9'h076,
    9'h067, 9'h04E, 9'h070, 9'h03B, NG,     NG,     NG,     9'h033,
    NG,     NG,     NG,     NG,     9'h01F, 9'h079, NG,     9'h071,
    9'h03D, 9'h01F, NG,     9'h005, 9'h07D, NG,     NG,     NG,
    9'h01C, 9'h05C, NG,     NG,     NG,     NG,     9'h01D, 9'h015,
    NG,     9'h00D, 9'h011, NG,     NG,     NG,     NG,     NG,
    NG,     NG,     NG,     NG,     NG,     NG,     NG,     NG
  };

endpackage

// ===== rtl/u2s_ifs.sv =====
// Valid/ready channel interfaces for the UTF-8 to seven-segment core.
// Depends on u2s_pkg for field widths.
interface u2s_in_if;
  logic                       valid;
  logic                       ready;
  logic [u2s_pkg::ByteW-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u2s_out_if;
  logic                       valid;
  logic                       ready;
  logic [u2s_pkg::SegW-1:0]   segments;
  logic [1:0]                 status;

  modport source (output valid, output segments, output status, input ready);
  modport sink   (input valid, input segments, input status, output ready);
endinterface

// ===== rtl/u2s_decode.sv =====
// UTF-8 byte decoder: keeps the pending count and partial code point, and
// registers one event per finished character or error. Depends on u2s_pkg and u2s_in_if.
module u2s_decode (
  input  logic                clk,
  input  logic                rst_n,
  u2s_in_if.sink              in_ch,
  input  logic                take,
  output u2s_pkg::u2s_event_t ev
);
  import u2s_pkg::*;

  logic [PendW-1:0] pend_r, pend_nxt;
  logic [CodeW-1:0] acc_r, acc_nxt;
  u2s_event_t       ev_r, ev_nxt;
  logic [OnesW-1:0] ones;
  logic [CodeW-1:0] acc_shift;
  logic             accept;
  logic             is_cont;

  function automatic logic [OnesW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [OnesW-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      n   = n + OnesW'(run);
    end
    return n;
  endfunction

  assign in_ch.ready = !ev_r.valid || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ones        = lead_ones(in_ch.text_byte);
  assign is_cont     = (in_ch.text_byte[7:6] == CONT_TAG);
  assign acc_shift   = {acc_r[CodeW-7:0], in_ch.text_byte[5:0]};
  assign ev          = ev_r;

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    ev_nxt   = '0;
    if (accept) begin
      if (pend_r == '0) begin
        // A stray continuation byte while idle is dropped.
        if (!is_cont) begin
          if (ones == OnesW'(ByteW)) begin
            ev_nxt.valid = 1'b1;
            ev_nxt.err   = 1'b1;
          end else if (ones == '0) begin
            ev_nxt.valid = 1'b1;
            ev_nxt.code  = {{(CodeW-7){1'b0}}, in_ch.text_byte[6:0]};
          end else begin
            pend_nxt = PendW'(ones - OnesW'(1));
            acc_nxt  = {{(CodeW-ByteW){1'b0}}, in_ch.text_byte & (8'hFF >> ones)};
          end
        end
      end else if (!is_cont) begin
        pend_nxt     = '0;
        acc_nxt      = '0;
        ev_nxt.valid = 1'b1;
        ev_nxt.err   = 1'b1;
      end else begin
        pend_nxt = pend_r - PendW'(1);
        if (pend_r == PendW'(1)) begin
          acc_nxt      = '0;
          ev_nxt.valid = 1'b1;
          ev_nxt.code  = acc_shift;
        end else begin
          acc_nxt = acc_shift;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      acc_r  <= '0;
      ev_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      if (in_ch.ready) begin
        ev_r <= ev_nxt;
      end
    end
  end

endmodule

// ===== rtl/u2s_glyph.sv =====
// Font stage: maps a decoded character to a segment pattern and status,
// and holds the result register. Depends on u2s_pkg and u2s_out_if.
module u2s_glyph (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u2s_pkg::u2s_event_t   ev,
  input  logic [u2s_pkg::SegW-1:0] unknown_pattern,
  output logic                  take,
  u2s_out_if.source             out_ch
);
  import u2s_pkg::*;

  logic              out_valid_r;
  logic [SegW-1:0]   seg_r, seg_nxt;
  status_t           stat_r, stat_nxt;
  logic [EntryW-1:0] entry;
  logic [6:0]        ascii_idx;
  logic [5:0]        cyr_idx;

  assign ascii_idx = ev.code[6:0] - 7'h20;
  assign cyr_idx   = ev.code[5:0] - CYR_FIRST[5:0];

  always_comb begin
    entry = NG;
    if (ev.code >= ASCII_FIRST && ev.code <= ASCII_LAST) begin
      entry = ASCII_FONT[ascii_idx];
    end else if (ev.code >= CYR_FIRST && ev.code < CYR_END) begin
      entry = CYR_FONT[cyr_idx];
    end
  end

  always_comb begin
    if (ev.err) begin
      seg_nxt  = '0;
      stat_nxt = STAT_ERROR;
    end else if (ev.code == '0) begin
      seg_nxt  = '0;
      stat_nxt = STAT_EOS;
    end else if (entry[EntryW-1]) begin
      seg_nxt  = unknown_pattern;
      stat_nxt = STAT_UNKNOWN;
    end else begin
      seg_nxt  = entry[SegW-1:0];
      stat_nxt = STAT_GLYPH;
    end
  end

  assign take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seg_r  <= seg_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.segments = seg_r;
  assign out_ch.status   = stat_r;

endmodule

// ===== rtl/utf8_to_seven_segment_core.sv =====
// Top level of the UTF-8 to seven-segment core: decoder, font stage and
// the unknown-pattern register. Depends on u2s_pkg, u2s_ifs, u2s_decode, u2s_glyph.
//
//   channel  | direction | fields
//   in_ch    | sink      | text_byte[7:0]
//   out_ch   | source    | segments[7:0], status[1:0]
//   cfg      | write     | cfg_we, cfg_wdata[7:0] (unknown pattern)
//
// One byte can be accepted every cycle while out_ch is not stalled. A
// character's result passes through the decoder's event register and then
// the result register before it is offered on out_ch.
// Reset is synchronous and clears the decoder state and both valid flags.
// A stall on out_ch fills the result register, then the event register,
// and only then drops in_ch.ready.
module utf8_to_seven_segment_core (
  input  logic                       clk,
  input  logic                       rst_n,
  u2s_in_if.sink                     in_ch,
  u2s_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [u2s_pkg::SegW-1:0]   cfg_wdata
);
  import u2s_pkg::*;

  logic [SegW-1:0] unknown_r;
  u2s_event_t      ev;
  logic            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unknown_r <= '0;
    end else if (cfg_we) begin
      unknown_r <= cfg_wdata;
    end
  end

  u2s_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .ev    (ev)
  );

  u2s_glyph u_glyph (
    .clk             (clk),
    .rst_n           (rst_n),
    .ev              (ev),
    .unknown_pattern (unknown_r),
    .take            (take),
    .out_ch          (out_ch)
  );

endmodule
